/* src/igfr_pkg.sv */
// Shared types and codes for the idle-gap frame receiver.
// No dependencies; imported by every module of the block.
package igfr_pkg;

  typedef enum logic [1:0] {
    ACT_START = 2'd0,
    ACT_BYTE  = 2'd1,
    ACT_TICK  = 2'd2,
    ACT_NONE  = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_CAP  = 2'd1,
    ST_FIRST_TO = 2'd2,
    ST_TOO_LONG = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CFG_FRAME_CAPACITY = 2'd0,
    CFG_FIRST_TIMEOUT  = 2'd1,
    CFG_IDLE_TIMEOUT   = 2'd2,
    CFG_UNUSED         = 2'd3
  } cfg_idx_e;

  localparam logic       KIND_DATA = 1'b0;
  localparam logic       KIND_END  = 1'b1;
  localparam logic [7:0] CAPACITY_RESET = 8'd255;
  localparam logic [15:0] FIRST_TIMEOUT_RESET = 16'd100;
  localparam logic [15:0] IDLE_TIMEOUT_RESET = 16'd5;
  localparam logic [15:0] ELAPSED_MAX = 16'hFFFF;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] rx_byte;
  } item_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] data_byte;
    logic [7:0] position;
    logic [1:0] status;
    logic [7:0] frame_length;
  } result_t;

endpackage

/* src/igfr_ctrl.sv */
// Frame delimiting state machine and configuration registers.
// Depends on igfr_pkg; turns one registered item into at most one result.
module igfr_ctrl
  import igfr_pkg::*;
(
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_we_i,
  input  logic [1:0]     cfg_idx_i,
  input  logic [15:0]    cfg_wdata_i,
  input  logic           item_valid_i,
  input  item_t          item_i,
  output logic           res_valid_o,
  output result_t        res_o
);

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_FIRST = 2'd1,
    PH_RECV  = 2'd2,
    PH_DRAIN = 2'd3
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [15:0] elapsed_q, elapsed_d;
  logic [7:0]  count_q, count_d;
  logic [1:0]  pending_q, pending_d;
  logic [7:0]  capacity_q;
  logic [15:0] first_to_q, idle_to_q;

  logic [15:0] elapsed_inc;
  logic [15:0] limit;
  logic        expired;

  assign elapsed_inc = (elapsed_q == ELAPSED_MAX) ? elapsed_q : elapsed_q + 16'd1;
  assign limit       = (phase_q == PH_FIRST) ? first_to_q : idle_to_q;
  assign expired     = (elapsed_inc >= limit);

  always_comb begin
    phase_d     = phase_q;
    elapsed_d   = elapsed_q;
    count_d     = count_q;
    pending_d   = pending_q;
    res_valid_o = 1'b0;
    res_o       = '0;
    if (item_valid_i) begin
      case (action_e'(item_i.action))
        ACT_START: begin
          elapsed_d = '0;
          count_d   = '0;
          if (capacity_q == 8'd0) begin
            phase_d   = PH_DRAIN;
            pending_d = ST_BAD_CAP;
          end else begin
            phase_d   = PH_FIRST;
            pending_d = ST_OK;
          end
        end
        ACT_BYTE: begin
          case (phase_q)
            PH_FIRST: begin
              res_valid_o     = 1'b1;
              res_o.kind      = KIND_DATA;
              res_o.data_byte = item_i.rx_byte;
              count_d         = 8'd1;
              elapsed_d       = '0;
              phase_d         = PH_RECV;
            end
            PH_RECV: begin
              elapsed_d = '0;
              if (count_q >= capacity_q) begin
                phase_d   = PH_DRAIN;
                pending_d = ST_TOO_LONG;
              end else begin
                res_valid_o     = 1'b1;
                res_o.kind      = KIND_DATA;
                res_o.data_byte = item_i.rx_byte;
                res_o.position  = count_q;
                count_d         = count_q + 8'd1;
              end
            end
            PH_DRAIN: begin
              elapsed_d = '0;
            end
            default: ;
          endcase
        end
        ACT_TICK: begin
          if (phase_q != PH_IDLE) begin
            elapsed_d = elapsed_inc;
            if (expired) begin
              res_valid_o = 1'b1;
              res_o.kind  = KIND_END;
              phase_d     = PH_IDLE;
              case (phase_q)
                PH_FIRST: res_o.status = ST_FIRST_TO;
                PH_RECV: begin
                  res_o.status       = ST_OK;
                  res_o.frame_length = count_q;
                end
                default:  res_o.status = pending_q;
              endcase
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_IDLE;
      elapsed_q  <= '0;
      count_q    <= '0;
      pending_q  <= ST_OK;
      capacity_q <= CAPACITY_RESET;
      first_to_q <= FIRST_TIMEOUT_RESET;
      idle_to_q  <= IDLE_TIMEOUT_RESET;
    end else begin
      phase_q   <= phase_d;
      elapsed_q <= elapsed_d;
      count_q   <= count_d;
      pending_q <= pending_d;
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_FRAME_CAPACITY: capacity_q <= cfg_wdata_i[7:0];
          CFG_FIRST_TIMEOUT:  first_to_q <= cfg_wdata_i;
          CFG_IDLE_TIMEOUT:   idle_to_q  <= cfg_wdata_i;
          default: ;
        endcase
      end
    end
  end

endmodule

/* src/igfr_out_fifo.sv */
// Three-entry result queue that decouples the result side from the input side.
// Depends on igfr_pkg for the result type.
module igfr_out_fifo
  import igfr_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  result_t    push_data_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output result_t    out_data_o,
  output logic [1:0] count_o
);

  localparam int unsigned Depth = 3;

  result_t    mem_q [Depth];
  logic [1:0] wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       pop;

  assign out_valid_o = (count_q != 2'd0);
  assign out_data_o  = mem_q[rd_ptr_q];
  assign pop         = out_valid_o && !out_stall_i;
  assign count_o     = count_q;

  function automatic logic [1:0] ptr_next(input logic [1:0] p);
    return (p == 2'(Depth - 1)) ? 2'd0 : p + 2'd1;
  endfunction

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ptr_next(wr_ptr_q);
      end
      if (pop) begin
        rd_ptr_q <= ptr_next(rd_ptr_q);
      end
      case ({push_i, pop})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

/* src/idle_gap_frame_receiver_top.sv */
// Top level of the idle-gap frame receiver: input register, control, result queue.
// Depends on igfr_pkg, igfr_ctrl and igfr_out_fifo.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries commands: start, received
//   byte, or a one-millisecond tick. Output channel (out_valid_o / out_stall_i)
//   carries stored bytes with their position and one frame end status per frame.
//   A transfer is one item moved at a clock edge with valid high and stall low.
//   Each transferred item is held in the input register, resolved by the control,
//   and its result is written into the result queue, from which it is offered.
//   Throughput: one item per cycle while in_stall_o is low; each item passes through
//   the input register and is resolved by a single compare and counter update.
//   in_stall_o is driven from registers only: it rises when the three-entry
//   result queue plus the item in flight could not take another result, so
//   a stalled receiver backs up the input once three results wait or are in flight.
//   Configuration writes (cfg_we_i, cfg_idx_i, cfg_wdata_i) take effect at the
//   next edge; write them only while the block is idle.
//   Reset: phase idle, counters cleared, capacity 255, first timeout 100,
//   idle timeout 5, queue empty.
module idle_gap_frame_receiver_top
  import igfr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  action_i,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        kind_o,
  output logic [7:0]  data_byte_o,
  output logic [7:0]  position_o,
  output logic [1:0]  status_o,
  output logic [7:0]  frame_length_o
);

  logic       in_valid_q;
  item_t      item_q;
  logic       accept;
  logic       res_valid;
  result_t    res;
  result_t    out_data;
  logic [1:0] fifo_count;

  assign in_stall_o = ({1'b0, fifo_count} + {2'b00, in_valid_q}) > 3'd2;
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q.action  <= action_i;
      item_q.rx_byte <= rx_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= accept;
    end
  end

  igfr_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .item_valid_i (in_valid_q),
    .item_i       (item_q),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  igfr_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .push_data_i (res),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data),
    .count_o     (fifo_count)
  );

  assign kind_o         = out_data.kind;
  assign data_byte_o    = out_data.data_byte;
  assign position_o     = out_data.position;
  assign status_o       = out_data.status;
  assign frame_length_o = out_data.frame_length;

endmodule

/* dv/testbench.sv */
// Self-checking testbench for idle_gap_frame_receiver_top: directed frames, random frames
// under several register settings, back-pressure and timeouts wider than eight bits.
// Depends on igfr_pkg and the block's RTL; keeps its own frame tracker to predict results.
module testbench;
  import igfr_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [1:0] {
    RX_IDLE  = 2'd0,
    RX_FIRST = 2'd1,
    RX_RECV  = 2'd2,
    RX_DRAIN = 2'd3
  } rx_phase_e;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  cfg_idx_e    cfg_idx = CFG_FRAME_CAPACITY;
  logic [15:0] cfg_wdata = 16'd0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  action = ACT_NONE;
  logic [7:0]  rx_byte = 8'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        kind;
  logic [7:0]  data_byte;
  logic [7:0]  position;
  logic [1:0]  status;
  logic [7:0]  frame_length;

  idle_gap_frame_receiver_top u_top (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .action_i       (action),
    .rx_byte_i      (rx_byte),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .kind_o         (kind),
    .data_byte_o    (data_byte),
    .position_o     (position),
    .status_o       (status),
    .frame_length_o (frame_length)
  );

  // frame tracker state and its copy of the registers
  rx_phase_e   trk_phase = RX_IDLE;
  logic [15:0] trk_elapsed = 16'd0;
  logic [7:0]  trk_count = 8'd0;
  status_e     trk_pending = ST_OK;
  logic [7:0]  trk_capacity = CAPACITY_RESET;
  logic [15:0] trk_first_to = FIRST_TIMEOUT_RESET;
  logic [15:0] trk_idle_to = IDLE_TIMEOUT_RESET;

  result_t due_results[$];
  int      mismatches = 0;
  int      accepted_items = 0;
  int      send_idle_pct = 12;
  int      recv_idle_pct = 55;
  int      hold_len = 0;
  int      hold_seq = 0;

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    #40_000_000;
    $display("== FAIL ==");
    $finish;
  end

  task automatic advance_frame_state(action_e act, logic [7:0] b);
    result_t r;
    bit      hit;
    logic [15:0] limit;
    r = '0;
    hit = 1'b0;
    case (act)
      ACT_START: begin
        trk_elapsed = 16'd0;
        trk_count = 8'd0;
        if (trk_capacity == 8'd0) begin
          trk_phase = RX_DRAIN;
          trk_pending = ST_BAD_CAP;
        end else begin
          trk_phase = RX_FIRST;
          trk_pending = ST_OK;
        end
      end
      ACT_BYTE: begin
        if (trk_phase == RX_FIRST) begin
          r.kind = KIND_DATA;
          r.data_byte = b;
          hit = 1'b1;
          trk_count = 8'd1;
          trk_elapsed = 16'd0;
          trk_phase = RX_RECV;
        end else if (trk_phase == RX_RECV) begin
          trk_elapsed = 16'd0;
          if (trk_count >= trk_capacity) begin
            trk_phase = RX_DRAIN;
            trk_pending = ST_TOO_LONG;
          end else begin
            r.kind = KIND_DATA;
            r.data_byte = b;
            r.position = trk_count;
            hit = 1'b1;
            trk_count = trk_count + 8'd1;
          end
        end else if (trk_phase == RX_DRAIN) begin
          trk_elapsed = 16'd0;
        end
      end
      ACT_TICK: begin
        if (trk_phase != RX_IDLE) begin
          if (trk_elapsed != ELAPSED_MAX) trk_elapsed = trk_elapsed + 16'd1;
          limit = (trk_phase == RX_FIRST) ? trk_first_to : trk_idle_to;
          if (trk_elapsed >= limit) begin
            hit = 1'b1;
            r.kind = KIND_END;
            case (trk_phase)
              RX_FIRST: r.status = ST_FIRST_TO;
              RX_RECV: begin
                r.status = ST_OK;
                r.frame_length = trk_count;
              end
              default: r.status = trk_pending;
            endcase
            trk_phase = RX_IDLE;
          end
        end
      end
      default: ;
    endcase
    if (hit) due_results.push_back(r);
  endtask

  task automatic send_item(action_e act, logic [7:0] b);
    in_valid <= 1'b1;
    action <= act;
    rx_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    accepted_items++;
    advance_frame_state(act, b);
    @(negedge clk);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(negedge clk);
    end
  endtask

  task automatic send_ticks(int n);
    repeat (n) send_item(ACT_TICK, 8'($urandom_range(255)));
  endtask

  task automatic send_bytes(int n);
    repeat (n) send_item(ACT_BYTE, 8'($urandom_range(255)));
  endtask

  task automatic close_frame();
    while (trk_phase != RX_IDLE) send_item(ACT_TICK, 8'($urandom_range(255)));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (due_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    case (idx)
      CFG_FRAME_CAPACITY: trk_capacity = val[7:0];
      CFG_FIRST_TIMEOUT:  trk_first_to = val;
      CFG_IDLE_TIMEOUT:   trk_idle_to = val;
      default: ;
    endcase
  endtask

  task automatic apply_config(logic [15:0] cap, logic [15:0] first_to, logic [15:0] idle_to);
    close_frame();
    wait_drained();
    write_reg(CFG_FRAME_CAPACITY, cap);
    write_reg(CFG_FIRST_TIMEOUT, first_to);
    write_reg(CFG_IDLE_TIMEOUT, idle_to);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_idling(int send_pct, int recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
  endtask

  function automatic int tick_span(logic [15:0] t);
    if (t <= 16'd1) return 0;
    return (t > 16'd11) ? 10 : int'(t) - 1;
  endfunction

  task automatic test_defaults();
    send_item(ACT_BYTE, 8'hA5);
    send_item(ACT_TICK, 8'h5A);
    send_item(ACT_NONE, 8'hFF);
    send_item(ACT_START, 8'h00);
    send_item(ACT_BYTE, 8'h00);
    send_item(ACT_BYTE, 8'hFF);
    send_ticks(5);
  endtask

  task automatic test_first_timeout();
    apply_config(16'd255, 16'd3, 16'd5);
    send_item(ACT_START, 8'h00);
    send_ticks(3);
    apply_config(16'd255, 16'd0, 16'd1);
    send_item(ACT_START, 8'h00);
    send_ticks(1);
    send_item(ACT_START, 8'h00);
    send_item(ACT_BYTE, 8'h3C);
    send_ticks(1);
  endtask

  task automatic test_bad_capacity();
    apply_config(16'd0, 16'd10, 16'd2);
    send_item(ACT_START, 8'h00);
    send_ticks(1);
    send_item(ACT_BYTE, 8'h81);
    send_ticks(2);
  endtask

  task automatic test_too_long();
    apply_config(16'd2, 16'd10, 16'd2);
    send_item(ACT_START, 8'h00);
    send_bytes(3);
    send_ticks(1);
    send_item(ACT_BYTE, 8'h7E);
    send_ticks(2);
  endtask

  task automatic test_restart();
    apply_config(16'd4, 16'd10, 16'd3);
    send_item(ACT_START, 8'h00);
    send_item(ACT_BYTE, 8'h11);
    send_item(ACT_START, 8'h00);
    send_item(ACT_BYTE, 8'h22);
    close_frame();
  endtask

  task automatic test_full_frame();
    apply_config(16'd255, 16'd100, 16'd2);
    send_item(ACT_START, 8'h00);
    send_bytes(255);
    close_frame();
    send_item(ACT_START, 8'h00);
    send_bytes(256);
    close_frame();
    wait_drained();
    write_reg(CFG_UNUSED, 16'($urandom_range(16'hFFFF)));
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic test_backpressure();
    set_idling(0, 0);
    apply_config(16'd255, 16'd50, 16'd4);
    hold_len = 400;
    hold_seq++;
    send_item(ACT_START, 8'h00);
    send_bytes(100);
    close_frame();
  endtask

  task automatic rand_config();
    logic [15:0] cap;
    logic [15:0] first_to;
    logic [15:0] idle_to;
    case ($urandom_range(9))
      0: cap = 16'd0;
      1: cap = 16'd1;
      2: cap = 16'd255;
      default: cap = 16'($urandom_range(12, 1));
    endcase
    if ($urandom_range(3) == 0) cap[15:8] = 8'($urandom_range(255));
    case ($urandom_range(19))
      0: first_to = 16'd0;
      1: first_to = 16'd1;
      2: first_to = 16'($urandom_range(60, 20));
      default: first_to = 16'($urandom_range(10, 2));
    endcase
    case ($urandom_range(19))
      0: idle_to = 16'd0;
      1: idle_to = 16'd1;
      2: idle_to = 16'($urandom_range(30, 12));
      default: idle_to = 16'($urandom_range(6, 2));
    endcase
    apply_config(cap, first_to, idle_to);
  endtask

  task automatic rand_frame();
    int nbytes;
    int cap_span;
    if ($urandom_range(9) == 0) send_item(ACT_NONE, 8'($urandom_range(255)));
    if ($urandom_range(15) == 0) send_item(ACT_BYTE, 8'($urandom_range(255)));
    send_item(ACT_START, 8'($urandom_range(255)));
    if ($urandom_range(7) == 0) begin
      close_frame();
      return;
    end
    send_ticks($urandom_range(tick_span(trk_first_to), 0));
    cap_span = (trk_capacity > 8'd12) ? 12 : int'(trk_capacity);
    nbytes = $urandom_range(cap_span + 2, 1);
    repeat (nbytes) begin
      send_item(ACT_BYTE, 8'($urandom_range(255)));
      case ($urandom_range(19))
        0: send_item(ACT_NONE, 8'($urandom_range(255)));
        1: send_item(ACT_START, 8'($urandom_range(255)));
        2: send_ticks($urandom_range(int'(trk_idle_to) + 2, 0));
        default: send_ticks($urandom_range(tick_span(trk_idle_to), 0));
      endcase
    end
    close_frame();
  endtask

  task automatic test_random();
    int mode;
    int target;
    for (mode = 0; mode < 3; mode++) begin
      case (mode)
        0: set_idling(12, 55);
        1: set_idling(55, 12);
        default: set_idling(0, 0);
      endcase
      target = accepted_items + 220;
      while (accepted_items < target) begin
        rand_config();
        repeat ($urandom_range(6, 2)) rand_frame();
      end
    end
  endtask

  task automatic test_long_timeouts();
    set_idling(0, 0);
    apply_config(16'hFF01, 16'h0123, 16'h0105);
    send_item(ACT_START, 8'h00);
    close_frame();
    send_item(ACT_START, 8'h00);
    send_item(ACT_BYTE, 8'hC3);
    close_frame();
    apply_config(16'd255, 16'd100, 16'd5);
  endtask

  always @(negedge clk) begin : recv_stall
    int hold_seen;
    int hold_cnt;
    if (hold_seen != hold_seq) begin
      hold_seen = hold_seq;
      hold_cnt = hold_len;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin : result_check
    result_t got;
    result_t want;
    if (rst_n && out_valid && !out_stall) begin
      got = {kind, data_byte, position, status, frame_length};
      if (due_results.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result kind=%0d data=%02h pos=%0d status=%0d len=%0d",
                 $time, got.kind, got.data_byte, got.position, got.status, got.frame_length);
      end else begin
        want = due_results.pop_front();
        if (got !== want) begin
          mismatches++;
          $display("%0t: mismatch expected kind=%0d data=%02h pos=%0d status=%0d len=%0d",
                   $time, want.kind, want.data_byte, want.position, want.status,
                   want.frame_length);
          $display("%0t:          actual kind=%0d data=%02h pos=%0d status=%0d len=%0d",
                   $time, got.kind, got.data_byte, got.position, got.status,
                   got.frame_length);
        end
      end
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    set_idling(12, 55);
    test_defaults();
    test_first_timeout();
    test_bad_capacity();
    test_too_long();
    test_restart();
    test_full_frame();
    test_backpressure();
    test_random();
    test_long_timeouts();
    wait_drained();
    repeat (8) @(negedge clk);
    if (mismatches == 0 && due_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
